// ===== rtl/core/lenient_utf8_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// lenient utf-8 decoder core: assertion macros
// immediate-style wrappers around concurrent assertions, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef LENIENT_UTF8_DECODER_CORE_DEFINES_SVH
`define LENIENT_UTF8_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LUD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define LUD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LUD_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define LUD_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/lud_pkg.sv =====
// ----------------------------------------------------------------------------
// lud_pkg
// shared types and constants of the lenient utf-8 decoder core
// ----------------------------------------------------------------------------
package lud_pkg;

    localparam int LUD_QUEUE_DEPTH = 2;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam logic [1:0] SEL_LEAD = 2'd0;
    localparam logic [1:0] SEL_C0   = 2'd1;

    // one request from front to back: raw replays, then an optional final result
    typedef struct packed {
        logic [1:0]  replay_n;
        logic [7:0]  lead;
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic        fin_valid;
        logic [20:0] fin_cp;
        logic [2:0]  fin_cnt;
        logic        fin_raw;
        logic        fin_eot;
    } lud_entry_t;

endpackage

// ===== rtl/core/lud_front.sv =====
// ----------------------------------------------------------------------------
// lud_front
// accepts text bytes, tracks the open sequence and classifies each byte
// ----------------------------------------------------------------------------
module lud_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_text_byte,
    input  logic                q_full,
    output logic                q_push,
    output lud_pkg::lud_entry_t q_entry
);
    import lud_pkg::*;

    logic [7:0] lead_reg, lead_next;
    logic [7:0] cont_reg [2];
    logic [1:0] pend_reg, pend_next;
    logic [2:0] exp_reg, exp_next;
    logic       accept;
    logic       is_cont;
    logic       store_en;
    logic       fresh;
    logic [7:0] b;

    assign b       = s_text_byte;
    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign is_cont = (b & CONT_MASK) == CONT_TAG;

    always_comb begin
        lead_next = lead_reg;
        pend_next = pend_reg;
        exp_next  = exp_reg;
        store_en  = 1'b0;
        fresh     = 1'b1;
        q_entry           = '0;
        q_entry.lead      = lead_reg;
        q_entry.c0        = cont_reg[0];
        q_entry.c1        = cont_reg[1];
        q_entry.fin_cnt   = 3'd1;
        if (pend_reg != 2'd0) begin
            if (is_cont) begin
                fresh = 1'b0;
                if (({1'b0, pend_reg} + 3'd1) >= exp_reg) begin
                    q_entry.fin_valid = 1'b1;
                    q_entry.fin_cnt   = exp_reg;
                    unique case (exp_reg)
                        LEN_TWO:   q_entry.fin_cp = {10'd0, lead_reg[4:0], b[5:0]};
                        LEN_THREE: q_entry.fin_cp = {5'd0, lead_reg[3:0], cont_reg[0][5:0],
                                                     b[5:0]};
                        default:   q_entry.fin_cp = {lead_reg[2:0], cont_reg[0][5:0],
                                                     cont_reg[1][5:0], b[5:0]};
                    endcase
                    lead_next = 8'd0;
                    pend_next = 2'd0;
                    exp_next  = LEN_NONE;
                end else begin
                    store_en  = 1'b1;
                    pend_next = pend_reg + 2'd1;
                end
            end else begin
                q_entry.replay_n = pend_reg;
                lead_next = 8'd0;
                pend_next = 2'd0;
                exp_next  = LEN_NONE;
            end
        end
        if (fresh) begin
            priority if (b == 8'd0) begin
                q_entry.fin_valid = 1'b1;
                q_entry.fin_cnt   = 3'd0;
                q_entry.fin_eot   = 1'b1;
            end else if (!b[7]) begin
                q_entry.fin_valid = 1'b1;
                q_entry.fin_cp    = {13'd0, b};
            end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
                lead_next = b;
                pend_next = 2'd1;
                exp_next  = LEN_TWO;
            end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
                lead_next = b;
                pend_next = 2'd1;
                exp_next  = LEN_THREE;
            end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
                lead_next = b;
                pend_next = 2'd1;
                exp_next  = LEN_FOUR;
            end else begin
                q_entry.fin_valid = 1'b1;
                q_entry.fin_cp    = {13'd0, b};
                q_entry.fin_raw   = 1'b1;
            end
        end
    end

    assign q_push = accept && (q_entry.fin_valid || (q_entry.replay_n != 2'd0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg <= 8'd0;
            pend_reg <= 2'd0;
            exp_reg  <= LEN_NONE;
        end else if (accept) begin
            lead_reg <= lead_next;
            pend_reg <= pend_next;
            exp_reg  <= exp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && store_en) begin
            cont_reg[pend_reg[0] ^ 1'b1] <= b;
        end
    end

endmodule

// ===== rtl/core/lud_queue.sv =====
// ----------------------------------------------------------------------------
// lud_queue
// small request queue between front and back
// ----------------------------------------------------------------------------
`include "lenient_utf8_decoder_core_defines.svh"

module lud_queue #(
    parameter int DEPTH = lud_pkg::LUD_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lud_pkg::lud_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output lud_pkg::lud_entry_t head,
    output logic                empty
);
    import lud_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lud_entry_t     slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `LUD_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH),
                    "queue overfill")
    `LUD_ASSERT_NXT(a_push_grows, aclk, aresetn, do_push && !do_pop,
                    count_reg == $past(count_reg) + 1'b1, "push lost")
    `LUD_ASSERT_IMP(a_ptr_sync, aclk, aresetn, empty || full,
                    wr_ptr_reg == rd_ptr_reg, "pointers out of step")

endmodule

// ===== rtl/core/lud_back.sv =====
// ----------------------------------------------------------------------------
// lud_back
// plays out each queued request as one or more results, one per cycle while m_ready holds
// ----------------------------------------------------------------------------
module lud_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  lud_pkg::lud_entry_t q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [20:0]         m_code_point,
    output logic [2:0]          m_byte_count,
    output logic                m_raw_fallback,
    output logic                m_end_of_text,
    output logic                m_last_of_run
);
    import lud_pkg::*;

    logic [1:0]  idx_reg;
    logic        m_valid_reg;
    logic [20:0] cp_reg;
    logic [2:0]  cnt_reg;
    logic        raw_reg, eot_reg, last_reg;
    logic        load, is_replay, last;
    logic [7:0]  raw_byte;

    assign load      = !q_empty && (!m_valid_reg || m_ready);
    assign is_replay = idx_reg < q_head.replay_n;
    assign last      = is_replay ? ((idx_reg == q_head.replay_n - 2'd1) && !q_head.fin_valid)
                                 : 1'b1;
    assign q_pop     = load && last;

    always_comb begin
        unique case (idx_reg)
            SEL_LEAD: raw_byte = q_head.lead;
            SEL_C0:   raw_byte = q_head.c0;
            default:  raw_byte = q_head.c1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= last ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            last_reg <= last;
            if (is_replay) begin
                cp_reg  <= {13'd0, raw_byte};
                cnt_reg <= 3'd1;
                raw_reg <= 1'b1;
                eot_reg <= 1'b0;
            end else begin
                cp_reg  <= q_head.fin_cp;
                cnt_reg <= q_head.fin_cnt;
                raw_reg <= q_head.fin_raw;
                eot_reg <= q_head.fin_eot;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_code_point   = cp_reg;
    assign m_byte_count   = cnt_reg;
    assign m_raw_fallback = raw_reg;
    assign m_end_of_text  = eot_reg;
    assign m_last_of_run  = last_reg;

endmodule

// ===== rtl/core/lenient_utf8_decoder_core.sv =====
// ----------------------------------------------------------------------------
// lenient_utf8_decoder_core
// streaming utf-8 to code point decoder with raw replay of broken sequences
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_       | in        | text_byte
//  m_       | out       | code_point, byte_count, raw_fallback, end_of_text,
//           |           | last_of_run
//
//  one byte accepted per cycle while the request queue has room
//  the results of a byte pass through the request queue, then the output register
//  the back end sends one result per cycle while m_ready holds; a breaking byte yields up to
//  four results (lead, two continuations, then its own result)
//  reset clears the open sequence, the queue and the output valid flag
//  a stalled m_ready fills the queue, then drops s_ready
// ----------------------------------------------------------------------------
module lenient_utf8_decoder_core #(
    parameter int QUEUE_DEPTH = lud_pkg::LUD_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [20:0] m_code_point,
    output logic [2:0]  m_byte_count,
    output logic        m_raw_fallback,
    output logic        m_end_of_text,
    output logic        m_last_of_run
);
    import lud_pkg::*;

    lud_entry_t push_entry, head;
    logic       push, full, pop, empty;

    lud_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .q_full      (full),
        .q_push      (push),
        .q_entry     (push_entry)
    );

    lud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    lud_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (empty),
        .q_head         (head),
        .q_pop          (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_point   (m_code_point),
        .m_byte_count   (m_byte_count),
        .m_raw_fallback (m_raw_fallback),
        .m_end_of_text  (m_end_of_text),
        .m_last_of_run  (m_last_of_run)
    );

endmodule
